### rtl/core/hid_keyboard_report_differ_macros.svh
// ----------------------------------------------------------------------------
// HID keyboard report differ: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_DIFFER_MACROS_SVH
`define HID_KEYBOARD_REPORT_DIFFER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define HKRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HKRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HKRD_ASSERT_SAME(lbl, ante, cons, msg)
`define HKRD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/hkrd_pkg.sv
// ----------------------------------------------------------------------------
// HID keyboard report differ: package
// Shared constants and types for the report compare and event emitter.
// ----------------------------------------------------------------------------
package hkrd_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int MOD_BITS  = 8;
  localparam int EVT_CNT   = MOD_BITS + 2 * KEY_SLOTS;

  localparam logic [7:0] SLOT_BYTE_OFFSET  = 8'd2;
  localparam logic [7:0] MIN_REPORT_LENGTH = 8'd3;
  localparam logic [7:0] FIRST_KEY_USAGE   = 8'd4;
  localparam logic [7:0] ROLLOVER_USAGE    = 8'd1;

  typedef logic [KEY_SLOTS-1:0][7:0] key_arr_t;
  typedef logic [EVT_CNT-1:0]        evt_mask_t;

  // One report's pending events plus what is needed to name them
  typedef struct packed {
    evt_mask_t  mask;
    logic [7:0] mods;
    key_arr_t   old_keys;
    key_arr_t   new_keys;
  } evt_t;

  typedef struct packed {
    logic keep;
    evt_t evt;
  } diff_t;

  // Emitter status toward the input stage
  typedef struct packed {
    logic free;
    logic busy;
  } emit_stat_t;

endpackage

### rtl/core/hid_keyboard_report_differ.sv
// ----------------------------------------------------------------------------
// HID keyboard report differ
// Turns boot-keyboard reports into modifier changes, key releases and key
// presses against the previously held report.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  force_release, report_length,
//                                            modifier_bits, key_slot0..5
//   out_     output     out_valid/out_stall  is_modifier, key_code,
//                                            released, last_event
//
// A report enters the input register and is compared with the held report
// when it moves to the event stage; from there its events go to the output
// register. Events go out one per cycle while out_stall is low; a report
// has 0 to 20 events, and a new report may enter the event stage as the
// last event of the old one goes out. Reset clears the held report and all
// valid flags. A stalled output holds its event and, once the event stage
// is full, stalls the input side.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_differ_macros.svh"

module hid_keyboard_report_differ import hkrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_force_release,
  input  logic [7:0] in_report_length,
  input  logic [7:0] in_modifier_bits,
  input  logic [7:0] in_key_slot0,
  input  logic [7:0] in_key_slot1,
  input  logic [7:0] in_key_slot2,
  input  logic [7:0] in_key_slot3,
  input  logic [7:0] in_key_slot4,
  input  logic [7:0] in_key_slot5,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_modifier,
  output logic [7:0] out_key_code,
  output logic       out_released,
  output logic       out_last_event
);

  logic       in_vld_r;
  logic       force_r;
  logic [7:0] len_r;
  logic [7:0] mods_r;
  key_arr_t   keys_r;
  logic [7:0] held_mods_r;
  key_arr_t   held_keys_r;
  diff_t      diff;
  emit_stat_t stat;
  logic       in_adv;

  assign in_adv   = in_vld_r && stat.free;
  assign in_stall = in_vld_r && !stat.free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      force_r   <= in_force_release;
      len_r     <= in_report_length;
      mods_r    <= in_modifier_bits;
      keys_r[0] <= in_key_slot0;
      keys_r[1] <= in_key_slot1;
      keys_r[2] <= in_key_slot2;
      keys_r[3] <= in_key_slot3;
      keys_r[4] <= in_key_slot4;
      keys_r[5] <= in_key_slot5;
    end
  end

  hkrd_diff u_diff (
    .force_release (force_r),
    .report_length (len_r),
    .modifier_bits (mods_r),
    .key_slots     (keys_r),
    .held_mods     (held_mods_r),
    .held_keys     (held_keys_r),
    .diff          (diff)
  );

  // advance the held report only for reports that are not dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mods_r <= '0;
      held_keys_r <= '0;
    end else if (in_adv && diff.keep) begin
      held_mods_r <= diff.evt.mods;
      held_keys_r <= diff.evt.new_keys;
    end
  end

  hkrd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_adv && diff.keep),
    .load_evt        (diff.evt),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_modifier (out_is_modifier),
    .out_key_code    (out_key_code),
    .out_released    (out_released),
    .out_last_event  (out_last_event)
  );

  `HKRD_ASSERT_NEXT(a_held_stable, !in_adv, $stable(held_keys_r) && $stable(held_mods_r), "held report changed without a report moving")
  `HKRD_ASSERT_SAME(a_more_pending, out_valid && !out_stall && !out_last_event, stat.busy, "non-final event sent with no event pending")
  `HKRD_ASSERT_SAME(a_key_usage, out_valid && !out_is_modifier, out_key_code >= FIRST_KEY_USAGE, "key event with a reserved usage")
  `HKRD_ASSERT_SAME(a_mod_index, out_valid && out_is_modifier, out_key_code < 8'(MOD_BITS), "modifier event index out of range")

endmodule

### rtl/core/hkrd_diff.sv
// ----------------------------------------------------------------------------
// HID keyboard report differ: report compare
// Normalizes a registered report and compares it with the held report,
// giving the mask of modifier, release and press events.
// ----------------------------------------------------------------------------
module hkrd_diff import hkrd_pkg::*; (
  input  logic       force_release,
  input  logic [7:0] report_length,
  input  logic [7:0] modifier_bits,
  input  key_arr_t   key_slots,
  input  logic [7:0] held_mods,
  input  key_arr_t   held_keys,
  output diff_t      diff
);

  always_comb begin
    logic [7:0] new_mods;
    key_arr_t   new_keys;
    logic       keep;
    logic       hit;
    evt_mask_t  mask;

    new_mods = '0;
    new_keys = '0;
    keep     = 1'b1;
    if (!force_release) begin
      keep     = (report_length >= MIN_REPORT_LENGTH);
      new_mods = modifier_bits;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if ((SLOT_BYTE_OFFSET + 8'(i)) < report_length) begin
          new_keys[i] = key_slots[i];
        end
      end
      // drop a rollover report
      if (new_keys[0] == ROLLOVER_USAGE) begin
        keep = 1'b0;
      end
    end

    mask = '0;
    mask[MOD_BITS-1:0] = new_mods ^ held_mods;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        hit = hit | (new_keys[j] == held_keys[i]);
      end
      mask[MOD_BITS + i] = (held_keys[i] >= FIRST_KEY_USAGE) && !hit;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        hit = hit | (held_keys[j] == new_keys[i]);
      end
      mask[MOD_BITS + KEY_SLOTS + i] = (new_keys[i] >= FIRST_KEY_USAGE) && !hit;
    end

    diff.keep         = keep;
    diff.evt.mask     = mask;
    diff.evt.mods     = new_mods;
    diff.evt.old_keys = held_keys;
    diff.evt.new_keys = new_keys;
  end

endmodule

### rtl/core/hkrd_emit.sv
// ----------------------------------------------------------------------------
// HID keyboard report differ: event emitter
// Holds one report's event mask and sends its lowest pending event to the
// output register each cycle the output side can take it.
// ----------------------------------------------------------------------------
module hkrd_emit import hkrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  evt_t       load_evt,
  output emit_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_modifier,
  output logic [7:0] out_key_code,
  output logic       out_released,
  output logic       out_last_event
);

  evt_t       evt_r;
  evt_mask_t  mask_nxt;
  evt_mask_t  pick;
  evt_mask_t  rest;
  logic       out_free;
  logic       emit;
  logic       out_vld_r;
  logic       is_mod_r;
  logic [7:0] code_r;
  logic       rel_r;
  logic       last_r;
  logic       is_mod_nxt;
  logic [7:0] code_nxt;
  logic       rel_nxt;

  assign out_free = !out_vld_r || !out_stall;
  assign emit     = (evt_r.mask != '0) && out_free;
  assign pick     = evt_r.mask & (~evt_r.mask + evt_mask_t'(1));
  assign rest     = evt_r.mask & ~pick;

  assign stat.busy = (evt_r.mask != '0);
  assign stat.free = emit ? (rest == '0) : (evt_r.mask == '0);

  always_comb begin
    is_mod_nxt = 1'b0;
    code_nxt   = '0;
    rel_nxt    = 1'b0;
    for (int m = 0; m < MOD_BITS; m++) begin
      if (pick[m]) begin
        is_mod_nxt = 1'b1;
        code_nxt   = 8'(m);
        rel_nxt    = !evt_r.mods[m];
      end
    end
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (pick[MOD_BITS + k]) begin
        code_nxt = evt_r.old_keys[k];
        rel_nxt  = 1'b1;
      end
      if (pick[MOD_BITS + KEY_SLOTS + k]) begin
        code_nxt = evt_r.new_keys[k];
      end
    end
  end

  always_comb begin
    mask_nxt = emit ? rest : evt_r.mask;
    if (load) begin
      mask_nxt = load_evt.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_r.mask <= '0;
    end else begin
      evt_r.mask <= mask_nxt;
    end
    if (load) begin
      evt_r.mods     <= load_evt.mods;
      evt_r.old_keys <= load_evt.old_keys;
      evt_r.new_keys <= load_evt.new_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= emit;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (emit) begin
      is_mod_r <= is_mod_nxt;
      code_r   <= code_nxt;
      rel_r    <= rel_nxt;
      last_r   <= (rest == '0);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_is_modifier = is_mod_r;
  assign out_key_code    = code_r;
  assign out_released    = rel_r;
  assign out_last_event  = last_r;

endmodule

### dv/hid_keyboard_report_differ_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID keyboard report differ testbench
// Sends boot-keyboard reports with random bursts and gaps, while the event
// side stalls on its own pattern. A behavioral model of the held report
// predicts each modifier, release and press event. A monitor compares every
// event, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module hid_keyboard_report_differ_tb;
  import hkrd_pkg::*;

  typedef struct packed {
    logic       force_rel;
    logic [7:0] len;
    logic [7:0] mods;
    key_arr_t   slots;
  } report_t;

  typedef struct packed {
    logic       is_mod;
    logic [7:0] code;
    logic       rel;
    logic       last_evt;
  } key_event_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_force_release;
  logic [7:0] in_report_length;
  logic [7:0] in_modifier_bits;
  logic [7:0] in_key_slot0;
  logic [7:0] in_key_slot1;
  logic [7:0] in_key_slot2;
  logic [7:0] in_key_slot3;
  logic [7:0] in_key_slot4;
  logic [7:0] in_key_slot5;
  logic       out_valid;
  logic       out_stall;
  logic       out_is_modifier;
  logic [7:0] out_key_code;
  logic       out_released;
  logic       out_last_event;

  // Model of the held report
  logic [7:0] model_mods;
  key_arr_t   model_keys;
  key_event_t pending_events[$];

  int mismatches;
  int burst_left;
  int hold_request;
  bit no_gaps;

  hid_keyboard_report_differ DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_force_release (in_force_release),
    .in_report_length (in_report_length),
    .in_modifier_bits (in_modifier_bits),
    .in_key_slot0     (in_key_slot0),
    .in_key_slot1     (in_key_slot1),
    .in_key_slot2     (in_key_slot2),
    .in_key_slot3     (in_key_slot3),
    .in_key_slot4     (in_key_slot4),
    .in_key_slot5     (in_key_slot5),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_modifier  (out_is_modifier),
    .out_key_code     (out_key_code),
    .out_released     (out_released),
    .out_last_event   (out_last_event)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic report_t mk_report(input logic fr, input logic [7:0] len,
                                        input logic [7:0] mods,
                                        input logic [7:0] s0, input logic [7:0] s1,
                                        input logic [7:0] s2, input logic [7:0] s3,
                                        input logic [7:0] s4, input logic [7:0] s5);
    report_t r;
    r.force_rel = fr;
    r.len       = len;
    r.mods      = mods;
    r.slots     = {s5, s4, s3, s2, s1, s0};
    return r;
  endfunction

  function automatic bit slots_contain(input key_arr_t s, input logic [7:0] u);
    for (int j = 0; j < KEY_SLOTS; j++)
      if (s[j] == u) return 1'b1;
    return 1'b0;
  endfunction

  // Diff the report against the held one and queue the resulting events
  task automatic predict_key_events(input report_t r);
    logic [7:0] mods;
    key_arr_t   keys;
    key_event_t evs[$];
    key_event_t ev;
    bit         dropped;
    mods    = '0;
    keys    = '0;
    dropped = 1'b0;
    if (!r.force_rel) begin
      if (r.len < MIN_REPORT_LENGTH) begin
        dropped = 1'b1;
      end else begin
        mods = r.mods;
        for (int i = 0; i < KEY_SLOTS; i++)
          if (32'(SLOT_BYTE_OFFSET) + i < 32'(r.len)) keys[i] = r.slots[i];
        if (keys[0] == ROLLOVER_USAGE) dropped = 1'b1;
      end
    end
    if (!dropped) begin
      for (int i = 0; i < MOD_BITS; i++) begin
        if (mods[i] != model_mods[i]) begin
          ev = '{is_mod: 1'b1, code: 8'(i), rel: ~mods[i], last_evt: 1'b0};
          evs.push_back(ev);
        end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (model_keys[i] >= FIRST_KEY_USAGE && !slots_contain(keys, model_keys[i])) begin
          ev = '{is_mod: 1'b0, code: model_keys[i], rel: 1'b1, last_evt: 1'b0};
          evs.push_back(ev);
        end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (keys[i] >= FIRST_KEY_USAGE && !slots_contain(model_keys, keys[i])) begin
          ev = '{is_mod: 1'b0, code: keys[i], rel: 1'b0, last_evt: 1'b0};
          evs.push_back(ev);
        end
      end
      model_mods = mods;
      model_keys = keys;
      if (evs.size() > 0) begin
        ev = evs[evs.size()-1];
        ev.last_evt = 1'b1;
        evs[evs.size()-1] = ev;
      end
      foreach (evs[k]) pending_events.push_back(evs[k]);
    end
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(0, 3);
    if (sel < 95) return $urandom_range(4, 25);
    return $urandom_range(26, 60);
  endfunction

  // Drive one report and hold it until the transfer
  task automatic send_report(input report_t r);
    int gap;
    if (burst_left == 0) begin
      if (!no_gaps) begin
        gap = pick_gap();
        if (gap > 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_force_release = r.force_rel;
    in_report_length = r.len;
    in_modifier_bits = r.mods;
    in_key_slot0     = r.slots[0];
    in_key_slot1     = r.slots[1];
    in_key_slot2     = r.slots[2];
    in_key_slot3     = r.slots[3];
    in_key_slot4     = r.slots[4];
    in_key_slot5     = r.slots[5];
    in_valid         = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_key_events(r);
  endtask

  // Pause the sender until every predicted event has left the block
  task automatic wait_events_drained();
    int waited;
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    waited     = 0;
    while (pending_events.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input key_event_t exp_ev);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected mod=%0d code=%02h rel=%0d last=%0d, got mod=%0d code=%02h rel=%0d last=%0d",
               what, exp_ev.is_mod, exp_ev.code, exp_ev.rel, exp_ev.last_evt,
               out_is_modifier, out_key_code, out_released, out_last_event);
  endtask

  // Event monitor
  always @(posedge clk) begin
    key_event_t exp_ev;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        note_mismatch("unexpected event", '0);
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_is_modifier !== exp_ev.is_mod || out_key_code !== exp_ev.code ||
            out_released !== exp_ev.rel || out_last_event !== exp_ev.last_evt)
          note_mismatch("event mismatch", exp_ev);
      end
    end
  end

  // Event side stall pattern; a hold-off request keeps the stall high until its count runs out
  initial begin
    int          stretch;
    int          held;
    stall_mode_t mode;
    out_stall = 1'b0;
    stretch   = 0;
    held      = 0;
    mode      = STALL_NONE;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        held         = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        out_stall = 1'b1;
        held--;
      end else begin
        if (stretch == 0) begin
          mode    = stall_mode_t'($urandom_range(0, 3));
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        case (mode)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:     out_stall = ~out_stall;
        endcase
      end
    end
  end

  task automatic test_modifiers();
    send_report(mk_report(1'b0, 8'd8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk_report(1'b0, 8'd8, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk_report(1'b0, 8'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_key_changes();
    send_report(mk_report(1'b0, 8'd8, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    // All modifiers, six releases and six presses at once
    send_report(mk_report(1'b0, 8'd8, 8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'h0A, 8'h0B, 8'h0C));
    send_report(mk_report(1'b0, 8'd8, 8'hFF, 8'h0B, 8'hFF, 8'h04, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_short_and_padded();
    send_report(mk_report(1'b0, 8'd0, 8'hA5, 8'hE0, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55));
    send_report(mk_report(1'b0, 8'd1, 8'h5A, 8'h01, 8'h66, 8'h77, 8'h88, 8'h99, 8'hAA));
    send_report(mk_report(1'b0, 8'd2, 8'h0F, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17));
    send_report(mk_report(1'b0, 8'd3, 8'h81, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25));
    send_report(mk_report(1'b0, 8'd5, 8'h81, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25));
    send_report(mk_report(1'b0, 8'd9, 8'h42, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35));
    send_report(mk_report(1'b0, 8'd255, 8'h24, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A));
  endtask

  task automatic test_rollover();
    send_report(mk_report(1'b0, 8'd8, 8'hC3, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
    // Rollover code outside the first slot is just a low usage
    send_report(mk_report(1'b0, 8'd8, 8'h24, 8'h35, 8'h01, 8'h37, 8'h38, 8'h39, 8'h3A));
  endtask

  task automatic test_force_release();
    send_report(mk_report(1'b1, 8'd0, 8'hFF, 8'h01, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48));
    send_report(mk_report(1'b1, 8'd8, 8'h3C, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55));
  endtask

  task automatic test_low_and_repeated_usages();
    send_report(mk_report(1'b0, 8'd8, 8'h00, 8'h00, 8'h02, 8'h03, 8'h00, 8'h04, 8'h04));
    send_report(mk_report(1'b0, 8'd8, 8'h00, 8'h05, 8'h05, 8'h05, 8'h03, 8'h00, 8'h00));
  endtask

  task automatic test_no_change();
    send_report(mk_report(1'b0, 8'd8, 8'h11, 8'h1C, 8'h1D, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk_report(1'b0, 8'd8, 8'h11, 8'h1C, 8'h1D, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // Mostly evolve the held report; the rest are short, rollover, forced or noise
  function automatic report_t random_report();
    report_t    r;
    int         kind;
    int         a;
    int         b;
    logic [7:0] t;
    r.force_rel = 1'b0;
    r.len       = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 255)) : 8'd8;
    case ($urandom_range(0, 3))
      0:       r.mods = model_mods ^ (8'h01 << $urandom_range(0, 7));
      1:       r.mods = 8'($urandom);
      2:       r.mods = model_mods;
      default: r.mods = model_mods ^ 8'($urandom);
    endcase
    for (int i = 0; i < KEY_SLOTS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: r.slots[i] = model_keys[i];
        5, 6, 7:       r.slots[i] = 8'($urandom_range(4, 32));
        8:             r.slots[i] = 8'h00;
        default:       r.slots[i] = 8'($urandom);
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      a = $urandom_range(0, KEY_SLOTS - 1);
      b = $urandom_range(0, KEY_SLOTS - 1);
      t = r.slots[a];
      r.slots[a] = r.slots[b];
      r.slots[b] = t;
    end
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      r.force_rel = 1'b1;
      r.len       = 8'($urandom);
    end else if (kind < 14) begin
      r.len = 8'($urandom_range(0, 2));
    end else if (kind < 20) begin
      r.slots[0] = ROLLOVER_USAGE;
      r.len      = 8'($urandom_range(3, 255));
    end else if (kind < 30) begin
      r.len = 8'($urandom_range(3, 255));
    end else if (kind < 35) begin
      r.len   = 8'($urandom);
      r.mods  = 8'($urandom);
      r.slots = key_arr_t'({$urandom, $urandom});
    end
    return r;
  endfunction

  task automatic test_random();
    for (int k = 0; k < 225; k++) begin
      send_report(random_report());
      if (k == 112) wait_events_drained();
    end
    wait_events_drained();
  endtask

  // Hold the event side off while reports keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = 80;
    no_gaps      = 1'b1;
    burst_left   = 0;
    for (int k = 0; k < 16; k++) begin
      if (k % 2 == 0)
        send_report(mk_report(1'b0, 8'd8, 8'hF0, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
      else
        send_report(mk_report(1'b0, 8'd8, 8'h0F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25));
    end
    no_gaps = 1'b0;
    wait_events_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_force_release = 1'b0;
    in_report_length = '0;
    in_modifier_bits = '0;
    in_key_slot0     = '0;
    in_key_slot1     = '0;
    in_key_slot2     = '0;
    in_key_slot3     = '0;
    in_key_slot4     = '0;
    in_key_slot5     = '0;
    model_mods       = '0;
    model_keys       = '0;
    mismatches       = 0;
    burst_left       = 0;
    hold_request     = 0;
    no_gaps          = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_modifiers();
    test_key_changes();
    test_short_and_padded();
    test_rollover();
    test_force_release();
    test_low_and_repeated_usages();
    test_no_change();
    wait_events_drained();
    test_backpressure();
    test_random();

    if (pending_events.size() != 0)
      $display("%0d predicted events never arrived", pending_events.size());
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
